// File: rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// command and character codes, channel payloads and controller interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int TAB_STEP   = 8;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  TEXT_ATTR  = 8'h0F;
  localparam logic [15:0] BLANK_CELL = {TEXT_ATTR, CH_SPACE};

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor_position;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_BLANK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic exec;
    logic ptr_clr;
    logic ptr_inc;
    logic move;
    logic blank;
    logic load_rsp;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       scroll;
    logic       ptr_move_end;
    logic       ptr_last;
  } ctl_sts_t;

endpackage
`default_nettype wire

// File: rtl/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor registers, sweep pointer and response register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_pkg::req_t     req,
  input  wire tcw_pkg::ctl_cmd_t cmd,
  output tcw_pkg::ctl_sts_t      sts,
  output tcw_pkg::rsp_t          rsp
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;

  tcw_pkg::req_t     req_q;
  tcw_pkg::rsp_t     rsp_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] ptr;
  logic [15:0]       mem [tcw_pkg::CELL_COUNT];
  logic [15:0]       rdata;

  logic [COL_W:0]    col_calc;
  logic [ROW_W:0]    row_calc;
  logic              printable;
  logic              scroll;
  logic              idx_ok;
  logic [ADDR_W-1:0] cur_addr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // cursor movement for a put
  always_comb begin
    col_calc  = {1'b0, col};
    row_calc  = {1'b0, row};
    printable = 1'b0;
    priority if (req_q.char_code == tcw_pkg::CH_LF) begin
      col_calc = '0;
      row_calc = {1'b0, row} + (ROW_W+1)'(1);
    end else if (req_q.char_code == tcw_pkg::CH_CR) begin
      col_calc = '0;
    end else if (req_q.char_code == tcw_pkg::CH_TAB) begin
      col_calc = ({1'b0, col} + (COL_W+1)'(tcw_pkg::TAB_STEP))
                 & ~(COL_W+1)'(tcw_pkg::TAB_STEP - 1);
    end else begin
      printable = 1'b1;
      col_calc  = {1'b0, col} + (COL_W+1)'(1);
    end
    if (32'(col_calc) >= tcw_pkg::COLUMNS) begin
      col_calc = '0;
      row_calc = row_calc + (ROW_W+1)'(1);
    end
    scroll = 32'(row_calc) >= tcw_pkg::ROWS;
  end

  assign cur_addr = ADDR_W'(32'(row) * tcw_pkg::COLUMNS + 32'(col));
  assign idx_ok   = 32'(req_q.cell_index) < tcw_pkg::CELL_COUNT;

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = tcw_pkg::BLANK_CELL;
    rd_en   = 1'b0;
    rd_addr = ptr + ADDR_W'(tcw_pkg::COLUMNS);
    if (cmd.exec && req_q.command == tcw_pkg::CMD_PUT && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = {tcw_pkg::TEXT_ATTR, req_q.char_code};
    end
    if (cmd.exec && req_q.command == tcw_pkg::CMD_READ && idx_ok) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(req_q.cell_index);
    end
    // scroll: read a row below, write the previous read one cell back
    if (cmd.move) begin
      rd_en   = 32'(ptr) < tcw_pkg::MOVE_COUNT;
      wr_en   = ptr != '0;
      wr_addr = ptr - ADDR_W'(1);
      wr_data = rdata;
    end
    if (cmd.blank) begin
      wr_en   = 1'b1;
      wr_addr = ptr;
      wr_data = tcw_pkg::BLANK_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ptr <= '0;
    end else begin
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + ADDR_W'(1);
      end
      if (cmd.exec) begin
        if (req_q.command == tcw_pkg::CMD_PUT) begin
          col <= col_calc[COL_W-1:0];
          row <= scroll ? ROW_W'(tcw_pkg::ROWS - 1) : row_calc[ROW_W-1:0];
        end else if (req_q.command == tcw_pkg::CMD_CLEAR) begin
          col <= '0;
          row <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q <= req;
    end
    if (cmd.load_rsp) begin
      rsp_q.cell_data <= (req_q.command == tcw_pkg::CMD_READ && idx_ok) ? rdata : 16'h0000;
      rsp_q.cursor_position <= 11'(32'(row) * tcw_pkg::COLUMNS + 32'(col));
    end
  end

  assign sts.command      = req_q.command;
  assign sts.scroll       = scroll;
  assign sts.ptr_move_end = 32'(ptr) == tcw_pkg::MOVE_COUNT;
  assign sts.ptr_last     = 32'(ptr) == tcw_pkg::CELL_COUNT - 1;
  assign rsp              = rsp_q;

endmodule
`default_nettype wire

// File: rtl/tcw_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_controller
// Sequencer for command execution, scroll and blanking sweeps, and the
// response channel handshake.
// ----------------------------------------------------------------------------
module tcw_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  input  wire tcw_pkg::ctl_sts_t sts,
  output tcw_pkg::ctl_cmd_t      cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        cmd.blank = 1'b1;
        if (sts.ptr_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      tcw_pkg::ST_IDLE: begin
        cmd.ptr_clr = 1'b1;
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.command == tcw_pkg::CMD_PUT && sts.scroll) begin
          state_next = tcw_pkg::ST_MOVE;
        end else if (sts.command == tcw_pkg::CMD_CLEAR) begin
          state_next = tcw_pkg::ST_BLANK;
        end else begin
          state_next = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_MOVE: begin
        cmd.move = 1'b1;
        if (sts.ptr_move_end) begin
          state_next = tcw_pkg::ST_BLANK;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      tcw_pkg::ST_BLANK: begin
        cmd.blank = 1'b1;
        if (sts.ptr_last) begin
          state_next = tcw_pkg::ST_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      tcw_pkg::ST_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_rsp = 1'b1;
          state_next   = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // output slot: filled on load, emptied when the transaction completes
  assign rsp_valid_next = cmd.load_rsp | (rsp_valid & rsp_stall);
  assign req_stall      = state != tcw_pkg::ST_IDLE;

endmodule
`default_nettype wire

// File: rtl/text_console_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console: 80x25 screen memory of attribute/character cells with
// a cursor, driven by put, clear and read commands.
// ----------------------------------------------------------------------------
// After reset the block blanks the whole screen memory, one cell per cycle,
// and holds req_stall high until done. A put, a read or an unused command
// is latched in ST_IDLE, executed in ST_EXEC and its response loaded in
// ST_RESP. A put that runs off the bottom row scrolls the screen: it moves
// 24 rows up and then blanks the bottom row. A clear blanks the whole screen.
// These sweeps go through the single write port of the screen memory one
// cell per cycle. The response sits in an output register, so a new command
// is taken while the previous response still waits.
// ----------------------------------------------------------------------------
module text_console_writer_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tcw_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output tcw_pkg::rsp_t      rsp
);

  tcw_pkg::ctl_cmd_t cmd;
  tcw_pkg::ctl_sts_t sts;

  tcw_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

// File: rtl/tcw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire tcw_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire tcw_pkg::rsp_t rsp
);

  // response held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // clearing pass after reset keeps the request side closed
  a_init_stall: assert property (@(posedge clk)
    !rst && $past(rst) |-> req_stall)
    else $error("request accepted during clearing pass");

  a_init_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken before work finished");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.cursor_position) < tcw_pkg::CELL_COUNT)
    else $error("cursor position off screen");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
